@@ hw/rtl/clle_pkg.sv @@
// ----------------------------------------------------------------------------
// clle_pkg
// Shared types and constants of the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int POS_W         = 4;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int HEAD_SLOT     = 0;
    localparam int FREE_SLOT     = 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_RANGE    = 2'd1,
        ST_FULL     = 2'd2,
        ST_PAST_END = 2'd3
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } res_t;

endpackage

@@ hw/rtl/clle_ram.sv @@
// ----------------------------------------------------------------------------
// clle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hw/rtl/clle_seq.sv @@
// ----------------------------------------------------------------------------
// clle_seq
// Operation sequencer: walks the link store, updates links and data slots.
// ----------------------------------------------------------------------------
module clle_seq
    import clle_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic [POS_W-1:0]   pos,
    input  logic [VALUE_W-1:0] val,
    output res_t               res,
    input  logic               res_ready
);

    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] END_MARK = LW'(SLOTS);
    localparam logic [AW-1:0] HEAD_A   = AW'(HEAD_SLOT);
    localparam logic [AW-1:0] FREE_A   = AW'(FREE_SLOT);
    localparam logic [AW-1:0] LAST_A   = AW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_FREE, S_WALK, S_STEP, S_RD_A, S_RD_B, S_RD_C,
        S_WR1, S_WR2, S_WR3, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      clr_reg, clr_next;
    logic               op_reg, op_next;
    logic [POS_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [LW-1:0]      na_reg, na_next;
    logic [LW-1:0]      nb_reg, nb_next;
    status_t            status_reg, status_next;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [LW-1:0]      rd_data;
    logic [LW-1:0]      rnext;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [LW-1:0]      wr_data;
    logic               dwr_en;
    logic               pos_bad;

    clle_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    clle_ram #(.WIDTH(VALUE_W), .DEPTH(SLOTS)) u_data_ram (
        .clk     (clk),
        .wr_en   (dwr_en),
        .wr_addr (slot_reg),
        .wr_data (val_reg),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    assign rnext   = (rd_data >= END_MARK) ? END_MARK : rd_data;
    assign pos_bad = (pos == '0) || (32'(pos) > SLOTS - 1);

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        cur_next    = cur_reg;
        slot_next   = slot_reg;
        na_next     = na_reg;
        nb_next     = nb_reg;
        status_next = status_reg;
        rd_en       = 1'b0;
        rd_addr     = cur_reg;
        wr_en       = 1'b0;
        wr_addr     = cur_reg;
        wr_data     = '0;
        dwr_en      = 1'b0;
        in_ready    = 1'b0;
        res.valid   = 1'b0;
        res.status  = status_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                if (clr_reg == HEAD_A || clr_reg == LAST_A)
                begin
                    wr_data = END_MARK;
                end
                else
                begin
                    wr_data = LW'(clr_reg) + LW'(1);
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == LAST_A)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next  = op;
                    val_next = val;
                    cnt_next = pos - POS_W'(1);
                    cur_next = HEAD_A;
                    if (pos_bad)
                    begin
                        status_next = ST_RANGE;
                        state_next  = S_OUT;
                    end
                    else if (op == OP_INSERT)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = FREE_A;
                        state_next = S_FREE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_FREE:
            begin
                if (rnext == END_MARK)
                begin
                    status_next = ST_FULL;
                    state_next  = S_OUT;
                end
                else
                begin
                    slot_next  = rnext[AW-1:0];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                rd_en = 1'b1;
                if (cnt_reg == '0)
                begin
                    rd_addr    = (op_reg == OP_INSERT) ? slot_reg : cur_reg;
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (rnext == END_MARK)
                begin
                    status_next = ST_PAST_END;
                    state_next  = S_OUT;
                end
                else
                begin
                    cur_next   = rnext[AW-1:0];
                    cnt_next   = cnt_reg - POS_W'(1);
                    state_next = S_WALK;
                end
            end
            S_RD_A:
            begin
                na_next = rnext;
                if (op_reg == OP_INSERT)
                begin
                    rd_en      = 1'b1;
                    state_next = S_RD_B;
                end
                else if (rnext == END_MARK)
                begin
                    status_next = ST_PAST_END;
                    state_next  = S_OUT;
                end
                else
                begin
                    slot_next  = rnext[AW-1:0];
                    rd_en      = 1'b1;
                    rd_addr    = rnext[AW-1:0];
                    state_next = S_RD_B;
                end
            end
            S_RD_B:
            begin
                nb_next = rnext;
                if (op_reg == OP_INSERT)
                begin
                    state_next = S_WR1;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = FREE_A;
                    state_next = S_RD_C;
                end
            end
            S_RD_C:
            begin
                na_next    = rnext;
                state_next = S_WR1;
            end
            S_WR1:
            begin
                wr_en = 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    wr_addr = FREE_A;
                    wr_data = na_reg;
                    dwr_en  = 1'b1;
                end
                else
                begin
                    wr_addr = cur_reg;
                    wr_data = nb_reg;
                end
                state_next = S_WR2;
            end
            S_WR2:
            begin
                wr_en      = 1'b1;
                wr_addr    = slot_reg;
                wr_data    = (op_reg == OP_INSERT) ? nb_reg : na_reg;
                state_next = S_WR3;
            end
            S_WR3:
            begin
                wr_en       = 1'b1;
                wr_addr     = (op_reg == OP_INSERT) ? cur_reg : FREE_A;
                wr_data     = LW'(slot_reg);
                status_next = ST_DONE;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        slot_reg   <= slot_next;
        na_reg     <= na_next;
        nb_reg     <= nb_next;
        status_reg <= status_next;
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !in_ready)
        else $error("input accepted during link store clear");

    a_link_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < SLOTS) && (wr_data <= END_MARK))
        else $error("link write outside the store or with stray link");

    a_read_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> state_reg != S_IDLE && state_reg != S_OUT)
        else $error("link read issued without a consuming step");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !rd_en)
        else $error("link read and write in the same cycle");

    a_done_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WR3 |=> state_reg == S_OUT && status_reg == ST_DONE)
        else $error("completed update not reported as done");

endmodule

@@ hw/rtl/cursor_linked_list_engine_top.sv @@
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_top
// Cursor linked list with free chain: insert at or delete at a list position.
// Pace: each walked link takes one link memory read.
// Throughput: one beat at a time; the next beat is taken once a result is out.
// Reset: asynchronous, active low; then the link store is rebuilt slot by slot
// (empty list, free chain from slot one) while s_tready stays low.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_top
    import clle_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[3:0], value[35:4], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // ok[0], status[2:1], zero pad
);

    res_t          res;
    logic          res_ready;
    logic          out_valid_reg, out_valid_next;
    logic          ok_reg, ok_next;
    status_t       status_reg, status_next;

    clle_seq #(.SLOTS(SLOTS)) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .op        (s_tuser),
        .pos       (s_tdata[POS_W-1:0]),
        .val       (s_tdata[POS_W+VALUE_W-1:POS_W]),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        status_next    = status_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            ok_next        = (res.status == ST_DONE);
            status_next    = res.status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        status_reg <= status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, status_reg, ok_reg};

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Drives insert and delete requests into the cursor linked list engine and
// checks every status beat against a predictor that keeps its own link store:
// the list from the head slot and the free chain from slot one. A directed
// part covers rejected positions, empty and full store, walks past the end
// and both ends of the value range. Random traffic follows, mostly in range
// of the current list and drifting between full and empty. Stalls come in
// bursts on both sides until a quiet tail.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import clle_pkg::*;

    localparam int SLOTS      = SLOTS_DEFAULT;
    localparam int RAND_OPS   = 1700;
    localparam int QUIET_OPS  = 200;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [4:0] END_MARK = 5'(SLOTS);

    typedef struct {
        logic    ok;
        status_t status;
    } verdict_t;

    class list_scoreboard;
        logic [4:0] next_slot [SLOTS];
        verdict_t   pending [$];
        int         errors;
        int         tally [4];

        function new();
            for (int k = 0; k < SLOTS; k++)
            begin
                next_slot[k] = 5'(k + 1);
                tally[k % 4] = 0;
            end
            next_slot[HEAD_SLOT] = END_MARK;
            next_slot[SLOTS-1]   = END_MARK;
            errors = 0;
        endfunction

        function logic [4:0] follow(logic [4:0] slot);
            if (slot >= END_MARK)
                return END_MARK;
            return (next_slot[slot] >= END_MARK) ? END_MARK : next_slot[slot];
        endfunction

        function logic [4:0] walk_from_head(int steps);
            logic [4:0] cur;
            cur = 5'(HEAD_SLOT);
            for (int k = 0; k < steps; k++)
            begin
                cur = follow(cur);
                if (cur == END_MARK)
                    return END_MARK;
            end
            return cur;
        endfunction

        function int list_len();
            logic [4:0] cur;
            int n;
            n   = 0;
            cur = follow(5'(HEAD_SLOT));
            while (cur != END_MARK && n < SLOTS)
            begin
                n++;
                cur = follow(cur);
            end
            return n;
        endfunction

        function status_t apply_insert(logic [3:0] pos);
            logic [4:0] slot;
            logic [4:0] prev;
            slot = follow(5'(FREE_SLOT));
            if (slot == END_MARK)
                return ST_FULL;
            prev = walk_from_head(int'(pos) - 1);
            if (prev == END_MARK)
                return ST_PAST_END;
            next_slot[FREE_SLOT] = follow(slot);
            next_slot[slot]      = follow(prev);
            next_slot[prev]      = slot;
            return ST_DONE;
        endfunction

        function status_t apply_delete(logic [3:0] pos);
            logic [4:0] prev;
            logic [4:0] victim;
            prev = walk_from_head(int'(pos) - 1);
            if (prev == END_MARK)
                return ST_PAST_END;
            victim = follow(prev);
            if (victim == END_MARK)
                return ST_PAST_END;
            next_slot[prev]      = follow(victim);
            next_slot[victim]    = follow(5'(FREE_SLOT));
            next_slot[FREE_SLOT] = victim;
            return ST_DONE;
        endfunction

        function void note_op(logic op, logic [3:0] pos);
            verdict_t v;
            if (pos < 1 || pos > SLOTS - 1)
                v.status = ST_RANGE;
            else if (op == OP_INSERT)
                v.status = apply_insert(pos);
            else
                v.status = apply_delete(pos);
            v.ok = (v.status == ST_DONE);
            tally[v.status]++;
            pending.push_back(v);
        endfunction

        function void check_result(logic ok, logic [1:0] status);
            verdict_t v;
            if (pending.size() == 0)
            begin
                $error("status beat with nothing pending: ok=%0d status=%0d", ok, status);
                errors++;
                return;
            end
            v = pending.pop_front();
            if (ok !== v.ok)
            begin
                $error("field ok: expected %0d, actual %0d", v.ok, ok);
                errors++;
            end
            if (status !== v.status)
            begin
                $error("field status: expected %0d, actual %0d", v.status, status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // position[3:0], value[35:4], zero pad
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // ok[0], status[2:1], zero pad

    list_scoreboard sb;
    bit quiet;
    int idle_cycles = 0;
    int results_seen = 0;

    cursor_linked_list_engine_top #(.SLOTS(SLOTS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_op(logic op, logic [3:0] pos, logic [31:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, val, pos};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_op(op, pos);
    endtask

    task automatic run_directed();
        send_op(OP_INSERT, 4'd0, 32'h7fff_ffff);
        send_op(OP_DELETE, 4'd0, 32'h0);
        send_op(OP_DELETE, 4'd1, 32'hffff_ffff);
        send_op(OP_INSERT, 4'd15, 32'h1234_5678);
        send_op(OP_INSERT, 4'd2, 32'h0);
        send_op(OP_INSERT, 4'd1, 32'h8000_0000);
        send_op(OP_INSERT, 4'd3, 32'h7fff_ffff);
        for (int k = 0; k < SLOTS - 3; k++)
            send_op(OP_INSERT, 4'($urandom_range(1, sb.list_len() + 1)),
                    (k % 2) ? 32'hffff_ffff : 32'h0);
        send_op(OP_INSERT, 4'd1, 32'h5a5a_a5a5);
        send_op(OP_DELETE, 4'd15, 32'h0);
        send_op(OP_DELETE, 4'd14, 32'h0);
        send_op(OP_DELETE, 4'd1, 32'h0);
    endtask

    task automatic run_random();
        int len;
        int hi;
        bit filling;
        logic op;
        logic [3:0] pos;
        filling = 1'b1;
        for (int i = 0; i < RAND_OPS; i++)
        begin
            quiet = (i >= RAND_OPS - QUIET_OPS);
            if (i % 64 == 63)
                filling = ~filling;
            len = sb.list_len();
            if ($urandom_range(0, 99) < 15)
            begin
                op  = 1'($urandom_range(0, 1));
                pos = 4'($urandom_range(0, 15));
            end
            else
            begin
                op = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? OP_INSERT : OP_DELETE;
                if (op == OP_INSERT)
                    hi = (len + 1 > SLOTS - 1) ? SLOTS - 1 : len + 1;
                else
                    hi = (len > 0) ? len : 1;
                pos = 4'($urandom_range(1, hi));
            end
            send_op(op, pos, $urandom());
        end
    endtask

    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata[0], m_tdata[2:1]);
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no beat accepted in %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        sb           = new();
        quiet        = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d status beats: %0d done, %0d out of range, %0d full, %0d past end",
                 results_seen, sb.tally[ST_DONE], sb.tally[ST_RANGE],
                 sb.tally[ST_FULL], sb.tally[ST_PAST_END]);
        $display("mismatches: %0d", sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/clle_pkg.sv
hw/rtl/clle_ram.sv
hw/rtl/clle_seq.sv
hw/rtl/cursor_linked_list_engine_top.sv
dv/tb.sv
